### sv/huffman_tree_build_and_decode_assert.svh
// Assertion macros for the Huffman tree build and decode block.
`ifndef HUFFMAN_TREE_BUILD_AND_DECODE_ASSERT_SVH
`define HUFFMAN_TREE_BUILD_AND_DECODE_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define HTB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define HTB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/htb_pkg.sv
// Package with the shared types and codes of the Huffman tree block.
package htb_pkg;
	localparam logic [2:0] ST_STORED = 3'd0;
	localparam logic [2:0] ST_BUILT  = 3'd1;
	localparam logic [2:0] ST_TAKEN  = 3'd2;
	localparam logic [2:0] ST_SYMBOL = 3'd3;
	localparam logic [2:0] ST_ERROR  = 3'd4;
	localparam logic       ACT_LOAD   = 1'b0;
	localparam logic       ACT_DECODE = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_SCAN_RD, S_SCAN, S_TAKE, S_MERGE, S_DONE,
		S_WALK, S_LEAF
	} state_t;
endpackage

### sv/htb_cmp.sv
// Shared compare unit that orders two nodes for the build.
module htb_cmp #(
	parameter int WW = 21,
	parameter int IW = 6
) (
	input  logic [WW-1:0] wa,
	input  logic [7:0]    sa,
	input  logic [IW-1:0] ia,
	input  logic [WW-1:0] wb,
	input  logic [7:0]    sb,
	input  logic [IW-1:0] ib,
	output logic          a_first
);
	always_comb begin
		if (wa != wb) begin
			a_first = wa < wb;
		end else if (sa != sb) begin
			a_first = sa < sb;
		end else begin
			a_first = ia > ib;
		end
	end
endmodule

### sv/huffman_tree_build_and_decode.sv
// Top level of the Huffman tree build and decode block.
//
//  Channel   Signals                                 Direction
//  request   start, busy, action, symbol, weight,    in (busy out)
//            last, code_bit
//  result    done, status, decoded_symbol            out
//
// A leaf load is taken while idle and its result follows in the next cycle.
// A decode bit holds busy through the walk and leaf states while the registered
// node table is read twice, and its result is registered in the leaf state. The
// build after the last leaf fills the pending set, then runs leaf_count - 1
// merges: each merge is two takes and a merge step, and each take scans the
// pending set, since one shared compare unit looks at one pending entry per cycle.
// Reset clears the control state only; the node table and pending set are
// memories with no reset. The receiver cannot stall: done is high for one
// cycle with each result.
module huffman_tree_build_and_decode #(
	parameter int MAX_SYMBOLS = 32,
	parameter int WEIGHT_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic       action,
	input  logic [7:0] symbol,
	input  logic [15:0] weight,
	input  logic       last,
	input  logic       code_bit,
	output logic       done,
	output logic [2:0] status,
	output logic [7:0] decoded_symbol
);
	import htb_pkg::*;

	localparam int DEPTH = 2 * MAX_SYMBOLS - 1;
	localparam int IW = $clog2(DEPTH + 1);
	localparam int PW = $clog2(MAX_SYMBOLS);
	localparam int CW = $clog2(MAX_SYMBOLS + 1);
	localparam int WW = WEIGHT_BITS + $clog2(MAX_SYMBOLS) + 1;
	// Weight bits actually kept from the 16-bit weight port.
	localparam int KW = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;

	// Node table memories.
	logic [7:0]    sym_mem [DEPTH];
	logic [WW-1:0] wt_mem  [DEPTH];
	logic [IW-1:0] lc_mem  [DEPTH];
	logic [IW-1:0] rc_mem  [DEPTH];
	logic          leaf_mem [DEPTH];
	logic [IW-1:0] pend_mem [MAX_SYMBOLS];

	state_t state_q, state_d;
	logic [CW-1:0] leaf_total_q;
	logic [IW-1:0] node_total_q, root_q, walk_q;
	logic          ready_q;
	logic [CW-1:0] count_q;    // pending entries left
	logic [CW-1:0] scan_q;     // scan position
	logic [PW-1:0] best_pos_q;
	logic [IW-1:0] best_idx_q, first_q;
	logic [WW-1:0] best_w_q, first_w_q;
	logic [7:0]    best_s_q;
	logic          second_q;   // second take of a merge
	logic          bit_q;
	logic          done_q;
	logic [2:0]    status_q;
	logic [7:0]    dsym_q;

	// Registered read ports.
	logic [IW-1:0] rd_addr;
	logic [7:0]    rd_sym_q;
	logic [WW-1:0] rd_wt_q;
	logic [IW-1:0] rd_lc_q, rd_rc_q;
	logic          rd_leaf_q;
	logic [PW-1:0] prd_addr;
	logic [IW-1:0] prd_q;
	logic [IW-1:0] cur_idx_q;

	logic a_first;

	htb_cmp #(.WW(WW), .IW(IW)) u_cmp (
		.wa(rd_wt_q), .sa(rd_sym_q), .ia(cur_idx_q),
		.wb(best_w_q), .sb(best_s_q), .ib(best_idx_q),
		.a_first(a_first)
	);

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = status_q;
	assign decoded_symbol = dsym_q;

	logic accept;
	assign accept = start && !busy;

	// Read addresses: the pending entry at the scan position, then its node.
	// Past the end of the set the tail entry is read, so that the take step
	// finds it on prd_q.
	always_comb begin
		prd_addr = scan_q[PW-1:0];
		if (scan_q >= count_q) begin
			prd_addr = PW'(count_q - 1'b1);
		end
	end

	always_comb begin
		rd_addr = prd_q;
		if (state_q == S_IDLE) begin
			rd_addr = walk_q;
		end else if (state_q == S_WALK) begin
			rd_addr = bit_q ? rd_rc_q : rd_lc_q;
		end
	end

	always_ff @(posedge clk) begin
		rd_sym_q  <= sym_mem[rd_addr[IW-1:0] < IW'(DEPTH) ? rd_addr : '0];
		rd_wt_q   <= wt_mem[rd_addr < IW'(DEPTH) ? rd_addr : '0];
		rd_lc_q   <= lc_mem[rd_addr < IW'(DEPTH) ? rd_addr : '0];
		rd_rc_q   <= rc_mem[rd_addr < IW'(DEPTH) ? rd_addr : '0];
		rd_leaf_q <= leaf_mem[rd_addr < IW'(DEPTH) ? rd_addr : '0];
		cur_idx_q <= rd_addr;
		prd_q     <= pend_mem[prd_addr];
	end

	// Memory writes.
	logic          leaf_wr;
	logic [IW-1:0] leaf_wr_idx;
	logic [CW-1:0] lt_eff;
	assign leaf_wr_idx = IW'(lt_eff);
	always_ff @(posedge clk) begin
		if (leaf_wr) begin
			sym_mem[leaf_wr_idx]  <= symbol;
			wt_mem[leaf_wr_idx]   <= WW'(weight[KW-1:0]);
			lc_mem[leaf_wr_idx]   <= '0;
			rc_mem[leaf_wr_idx]   <= '0;
			leaf_mem[leaf_wr_idx] <= 1'b1;
		end else if (state_q == S_MERGE) begin
			sym_mem[node_total_q]  <= 8'd0;
			wt_mem[node_total_q]   <= first_w_q + best_w_q;
			lc_mem[node_total_q]   <= first_q;
			rc_mem[node_total_q]   <= best_idx_q;
			leaf_mem[node_total_q] <= 1'b0;
		end
	end

	// Pending set writes: fill on init, move tail on take, append on merge.
	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			pend_mem[scan_q[PW-1:0]] <= IW'(scan_q);
		end else if (state_q == S_TAKE) begin
			pend_mem[best_pos_q] <= prd_q;
		end else if (state_q == S_MERGE) begin
			pend_mem[count_q[PW-1:0]] <= node_total_q;
		end
	end

	// Store the leaf when the load is valid.
	logic do_store;
	always_comb begin
		lt_eff = ready_q ? '0 : leaf_total_q;
		do_store = accept && action == ACT_LOAD && symbol != 8'd0
			&& lt_eff < CW'(MAX_SYMBOLS);
		leaf_wr = do_store;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && action == ACT_LOAD && do_store && last
					&& lt_eff + 1'b1 >= CW'(2)) begin
					state_d = S_INIT;
				end else if (accept && action == ACT_DECODE && ready_q) begin
					state_d = S_WALK;
				end
			end
			S_INIT: begin
				if (scan_q + 1'b1 == leaf_total_q) begin
					state_d = (leaf_total_q > CW'(1)) ? S_SCAN_RD : S_DONE;
				end
			end
			// The pending read and then the node read are filled here.
			S_SCAN_RD: state_d = (scan_q == CW'(1)) ? S_SCAN : S_SCAN_RD;
			S_SCAN: begin
				if (scan_q == count_q + 1'b1) begin
					state_d = S_TAKE;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_TAKE: state_d = second_q ? S_MERGE : S_SCAN_RD;
			S_MERGE: state_d = (count_q + 1'b1 > CW'(1)) ? S_SCAN_RD : S_DONE;
			S_DONE: state_d = S_IDLE;
			S_WALK: state_d = S_LEAF;
			S_LEAF: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaf_total_q <= '0;
			node_total_q <= '0;
			root_q <= '0;
			walk_q <= '0;
			ready_q <= 1'b0;
			count_q <= '0;
			scan_q <= '0;
			second_q <= 1'b0;
			done_q <= 1'b0;
			status_q <= ST_STORED;
			dsym_q <= '0;
			bit_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bit_q <= code_bit;
						dsym_q <= '0;
						if (action == ACT_LOAD) begin
							if (ready_q) begin
								ready_q <= 1'b0;
							end
							if (!do_store) begin
								leaf_total_q <= lt_eff;
								status_q <= ST_ERROR;
								done_q <= 1'b1;
							end else if (last && lt_eff < CW'(1)) begin
								leaf_total_q <= '0;
								status_q <= ST_ERROR;
								done_q <= 1'b1;
							end else begin
								leaf_total_q <= lt_eff + 1'b1;
								if (last) begin
									scan_q <= '0;
								end else begin
									status_q <= ST_STORED;
									done_q <= 1'b1;
								end
							end
						end else if (!ready_q) begin
							status_q <= ST_ERROR;
							done_q <= 1'b1;
						end
					end
				end
				S_INIT: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q + 1'b1 == leaf_total_q) begin
						count_q <= leaf_total_q;
						node_total_q <= IW'(leaf_total_q);
						scan_q <= '0;
						second_q <= 1'b0;
					end
				end
				S_SCAN_RD: begin
					scan_q <= scan_q + 1'b1;
				end
				S_SCAN: begin
					// The node of the entry at scan-2 is on the read port.
					if (scan_q == CW'(2) || a_first) begin
						best_pos_q <= PW'(scan_q - CW'(2));
						best_idx_q <= cur_idx_q;
						best_w_q <= rd_wt_q;
						best_s_q <= rd_sym_q;
					end
					scan_q <= scan_q + 1'b1;
				end
				S_TAKE: begin
					// Tail entry is on prd_q; it moves into the taken slot.
					count_q <= count_q - 1'b1;
					scan_q <= '0;
					if (!second_q) begin
						first_q <= best_idx_q;
						first_w_q <= best_w_q;
						second_q <= 1'b1;
					end
				end
				S_MERGE: begin
					second_q <= 1'b0;
					count_q <= count_q + 1'b1;
					node_total_q <= node_total_q + 1'b1;
					root_q <= node_total_q;
					walk_q <= node_total_q;
					scan_q <= '0;
				end
				S_DONE: begin
					ready_q <= 1'b1;
					status_q <= ST_BUILT;
					done_q <= 1'b1;
				end
				S_WALK: begin
				end
				S_LEAF: begin
					done_q <= 1'b1;
					if (rd_leaf_q) begin
						status_q <= ST_SYMBOL;
						dsym_q <= rd_sym_q;
						walk_q <= root_q;
					end else begin
						status_q <= ST_TAKEN;
						walk_q <= cur_idx_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`include "huffman_tree_build_and_decode_assert.svh"

	`HTB_ASSERT_IMP(a_status_range, done, status <= ST_ERROR, "result status out of range")
	`HTB_ASSERT_NEXT(a_leaf_result, state_q == S_LEAF, done, "walk step gave no result")
	`HTB_ASSERT_IMP(a_done_idle, done, !busy, "result while busy")
	`HTB_ASSERT_IMP(a_sym_zero, done && status != ST_SYMBOL, decoded_symbol == 8'd0,
		"symbol nonzero without decode")
endmodule

### tb/tb.sv
// Self-checking testbench for the Huffman tree build and decode block.
`timescale 1ns / 100ps

// Holds its own copy of the node table and predicts one result per request.
class huff_scoreboard;
	typedef struct packed {
		logic [2:0] status;
		logic [7:0] sym;
	} huff_result_t;

	localparam int LEAF_MAX = 32;
	localparam int NODE_MAX = 2 * LEAF_MAX - 1;

	logic [7:0]  tab_sym[NODE_MAX];
	int unsigned tab_wt[NODE_MAX];
	int unsigned tab_left[NODE_MAX];
	int unsigned tab_right[NODE_MAX];
	bit          tab_leaf[NODE_MAX];
	int unsigned pend[LEAF_MAX];
	int unsigned leaves, nodes, root, cursor;
	bit          ready;

	huff_result_t pending_results[$];
	int errors, n_loads, n_builds, n_symbols, n_errs;

	function new();
		leaves = 0; nodes = 0; root = 0; cursor = 0; ready = 0;
		errors = 0; n_loads = 0; n_builds = 0; n_symbols = 0; n_errs = 0;
	endfunction

	// True when node a is taken ahead of node b.
	function bit ahead(int unsigned a, int unsigned b);
		if (tab_wt[a] != tab_wt[b])
			return tab_wt[a] < tab_wt[b];
		if (tab_sym[a] != tab_sym[b])
			return tab_sym[a] < tab_sym[b];
		return a > b;
	endfunction

	function int unsigned pull_least(ref int unsigned cnt);
		int unsigned best, node;
		best = 0;
		for (int unsigned i = 1; i < cnt; i++)
			if (ahead(pend[i], pend[best]))
				best = i;
		node = pend[best];
		cnt--;
		pend[best] = pend[cnt];
		return node;
	endfunction

	function void grow_tree();
		int unsigned cnt, a, b;
		cnt = leaves;
		for (int unsigned i = 0; i < leaves; i++)
			pend[i] = i;
		nodes = leaves;
		while (cnt > 1) begin
			a = pull_least(cnt);
			b = pull_least(cnt);
			tab_sym[nodes] = 8'd0;
			tab_wt[nodes] = tab_wt[a] + tab_wt[b];
			tab_left[nodes] = a;
			tab_right[nodes] = b;
			tab_leaf[nodes] = 1'b0;
			pend[cnt] = nodes;
			cnt++;
			nodes++;
		end
		root = pend[0];
		cursor = root;
		ready = 1'b1;
	endfunction

	// Notes one accepted request and queues the result it must cause.
	function void note_request(logic act, logic [7:0] sym, logic [15:0] wt, logic lst,
			logic cb);
		huff_result_t r;
		int unsigned nxt;
		r.sym = 8'd0;
		if (act == htb_pkg::ACT_LOAD) begin
			if (ready) begin
				ready = 1'b0;
				leaves = 0;
			end
			if (sym == 8'd0 || leaves >= LEAF_MAX) begin
				r.status = htb_pkg::ST_ERROR;
			end else begin
				tab_sym[leaves] = sym;
				tab_wt[leaves] = wt;
				tab_left[leaves] = 0;
				tab_right[leaves] = 0;
				tab_leaf[leaves] = 1'b1;
				leaves++;
				r.status = htb_pkg::ST_STORED;
				if (lst) begin
					if (leaves < 2) begin
						leaves = 0;
						r.status = htb_pkg::ST_ERROR;
					end else begin
						grow_tree();
						r.status = htb_pkg::ST_BUILT;
					end
				end
			end
		end else begin
			if (!ready) begin
				r.status = htb_pkg::ST_ERROR;
			end else begin
				nxt = cb ? tab_right[cursor] : tab_left[cursor];
				if (tab_leaf[nxt]) begin
					r.sym = tab_sym[nxt];
					r.status = htb_pkg::ST_SYMBOL;
					cursor = root;
				end else begin
					cursor = nxt;
					r.status = htb_pkg::ST_TAKEN;
				end
			end
		end
		case (r.status)
			htb_pkg::ST_STORED: n_loads++;
			htb_pkg::ST_BUILT:  n_builds++;
			htb_pkg::ST_SYMBOL: n_symbols++;
			htb_pkg::ST_ERROR:  n_errs++;
			default: ;
		endcase
		pending_results = {pending_results, r};
	endfunction

	// Compares one result against the oldest expectation.
	function void check_result(logic [2:0] st, logic [7:0] sym);
		huff_result_t r;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result status=%0d symbol=%0d", $time, st, sym);
			errors++;
			return;
		end
		r = pending_results.pop_front();
		if (st !== r.status) begin
			$display("%0t: status expected %0d, actual %0d", $time, r.status, st);
			errors++;
		end
		if (sym !== r.sym) begin
			$display("%0t: decoded_symbol expected %0d, actual %0d", $time, r.sym, sym);
			errors++;
		end
	endfunction
endclass

module tb;
	import htb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic        action = ACT_LOAD;
	logic [7:0]  symbol = 8'd0;
	logic [15:0] weight = 16'd0;
	logic        last = 1'b0;
	logic        code_bit = 1'b0;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  decoded_symbol;

	huff_scoreboard sb = new();
	int burst_left = 0;
	int sent = 0;

	huffman_tree_build_and_decode dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .symbol(symbol), .weight(weight), .last(last),
		.code_bit(code_bit), .done(done), .status(status),
		.decoded_symbol(decoded_symbol)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Results cannot be held off, so every strobe is checked on the edge it ends.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(status, decoded_symbol);
	end

	// Drives one request at a falling edge and waits until the block takes it.
	// The sender runs in bursts; start only drops when a gap is inserted, so
	// back-to-back requests keep start high across the boundary.
	task automatic send_request(logic act, logic [7:0] sym, logic [15:0] wt, logic lst,
			logic cb);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			start <= 1'b0;
			repeat (gap) @(negedge clk);
			// Roughly one burst in four is long, so some stretches never idle.
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		action <= act;
		symbol <= sym;
		weight <= wt;
		last <= lst;
		code_bit <= cb;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(act, sym, wt, lst, cb);
		sent++;
	endtask

	task automatic load_leaf(logic [7:0] sym, logic [15:0] wt, logic lst);
		send_request(ACT_LOAD, sym, wt, lst, 1'($urandom_range(0, 1)));
	endtask

	task automatic decode_bit(logic cb);
		send_request(ACT_DECODE, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
			1'($urandom_range(0, 1)), cb);
	endtask

	// Random leaf weight: mostly full range, sometimes tiny or near the top to force ties.
	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 3));
			1: return 16'hFFFF - 16'($urandom_range(0, 3));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// Loads a whole alphabet of n leaves, the last one starting the build.
	task automatic load_alphabet(int n, bit narrow_syms);
		logic [7:0] s;
		for (int i = 0; i < n; i++) begin
			s = narrow_syms ? 8'($urandom_range(1, 4)) : 8'($urandom_range(1, 255));
			load_leaf(s, pick_weight(), i == n - 1);
		end
	endtask

	initial begin
		int n;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: decode with no tree, reserved zero symbol, a tree of
		// one leaf, exact ties, weight extremes and internal-versus-leaf ties.
		decode_bit(1'b0);
		decode_bit(1'b1);
		load_leaf(8'd0, 16'd7, 1'b1);
		load_leaf(8'hFF, 16'hFFFF, 1'b1);
		load_leaf(8'd5, 16'd100, 1'b0);
		decode_bit(1'b0);
		load_leaf(8'd5, 16'd100, 1'b1);
		decode_bit(1'b0);
		decode_bit(1'b1);
		load_leaf(8'd1, 16'd0, 1'b0);
		load_leaf(8'hFF, 16'hFFFF, 1'b0);
		load_leaf(8'd2, 16'd0, 1'b1);
		decode_bit(1'b1);
		decode_bit(1'b0);
		decode_bit(1'b0);
		decode_bit(1'b0);
		decode_bit(1'b1);
		// Weights 1, 1, 2: the first joined node ties with the weight-2 leaf.
		load_leaf(8'd9, 16'd1, 1'b0);
		load_leaf(8'd8, 16'd1, 1'b0);
		load_leaf(8'd7, 16'd2, 1'b1);
		decode_bit(1'b0);
		decode_bit(1'b0);
		decode_bit(1'b1);
		decode_bit(1'b1);

		// Random part: mostly well-formed load-then-decode sessions with small
		// alphabets, a few large ones, and some noise mixed in.
		while (sent < 620) begin
			case ($urandom_range(0, 9))
				0: load_leaf(8'd0, pick_weight(), 1'($urandom_range(0, 1)));
				1: decode_bit(1'($urandom_range(0, 1)));
				2: load_leaf(8'($urandom_range(1, 255)), pick_weight(), 1'b1);
				default: begin
					n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20)
						: $urandom_range(2, 8);
					load_alphabet(n, $urandom_range(0, 2) == 0);
					repeat ($urandom_range(10, 40))
						decode_bit(1'($urandom_range(0, 1)));
				end
			endcase
		end

		// A full alphabet, then overflow. Overflow leaves the load stuck at
		// capacity with no tree, so it has to come last.
		load_alphabet(32, 1'b0);
		repeat (30) decode_bit(1'($urandom_range(0, 1)));
		for (int i = 0; i < 32; i++)
			load_leaf(8'($urandom_range(1, 255)), pick_weight(), 1'b0);
		load_leaf(8'($urandom_range(1, 255)), pick_weight(), 1'b1);
		load_leaf(8'($urandom_range(1, 255)), pick_weight(), 1'b0);
		decode_bit(1'b0);

		@(negedge clk);
		start <= 1'b0;
		for (int i = 0; i < 2000 && sb.pending_results.size() != 0; i++)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.pending_results.size() != 0) begin
			$display("%0t: results expected %0d more, actual 0",
				$time, sb.pending_results.size());
			sb.errors++;
		end

		$display("Sent %0d requests: %0d leaves stored, %0d trees built,", sent,
			sb.n_loads, sb.n_builds);
		$display("%0d symbols decoded and %0d error results.", sb.n_symbols, sb.n_errs);
		if (sb.errors == 0)
			$display("huffman_tree_build_and_decode: match");
		else
			$display("huffman_tree_build_and_decode: mismatch");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#20ms;
		$display("huffman_tree_build_and_decode: mismatch");
		$finish;
	end
endmodule
